>>> rtl/fpe_pkg.sv
// Shared widths, constants and functions for the frustum plane extract and point test.
// Has no dependencies. Used by the request interface, the top level and the dv files.
package fpe_pkg;

    localparam int REQ_W   = 2;
    localparam int IDX_W   = 4;
    localparam int VAL_W   = 32;
    localparam int PLANE_COUNT = 6;
    localparam int PLANE_W = 3;

    localparam logic [REQ_W-1:0] REQ_LOAD_PROJ = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_VIEW = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BUILD     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TEST      = 2'd3;

    // Clip matrix column that is combined with column three for each plane:
    // right, left, bottom, top, far, near.
    function automatic logic [1:0] plane_col(input logic [PLANE_W-1:0] p);
        logic [1:0] col;
        case (p)
            3'd0, 3'd1: col = 2'd0;
            3'd2, 3'd3: col = 2'd1;
            default:    col = 2'd2;
        endcase
        return col;
    endfunction

    // True where the plane takes the difference rather than the sum.
    function automatic logic plane_neg(input logic [PLANE_W-1:0] p);
        logic neg;
        case (p)
            3'd0, 3'd3, 3'd4: neg = 1'b1;
            default:          neg = 1'b0;
        endcase
        return neg;
    endfunction

endpackage

>>> rtl/fpe_in_if.sv
// Request channel: valid/ready handshake carrying one request word.
// Depends on fpe_pkg for the field widths.
interface fpe_in_if
    import fpe_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic [IDX_W-1:0]        elem_index;
    logic signed [VAL_W-1:0] elem_value;
    logic signed [VAL_W-1:0] point_x;
    logic signed [VAL_W-1:0] point_y;
    logic signed [VAL_W-1:0] point_z;

    modport source (output valid, req_type, elem_index, elem_value, point_x, point_y,
                    point_z, input ready);
    modport sink   (input valid, req_type, elem_index, elem_value, point_x, point_y,
                    point_z, output ready);
endinterface

>>> rtl/fpe_out_if.sv
// Result channel: valid/ready handshake carrying the inside flag of one point test.
// Has no dependencies.
interface fpe_out_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink   (input valid, inside_res, output ready);
endinterface

>>> rtl/frustum_plane_extract_and_point_test.sv
// Frustum plane extraction and point test, top level. Uses fpe_pkg, fpe_in_if, fpe_out_if.
// A load request gives no word. A build and a point test run term by term, because
// every product goes through the one shared 33 x 33 multiplier (read, multiply,
// accumulate per term). Only point tests return a word.
// The block is not ready while a build or a test runs.
module frustum_plane_extract_and_point_test
    import fpe_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    fpe_in_if.sink    in_ch,
    fpe_out_if.source out_ch
);

    localparam int OPND_W = VAL_W + 1;
    localparam int PROD_W = 2 * OPND_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic signed [OPND_W-1:0] D_SCALE = OPND_W'(1) << FRAC_BITS;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_BRD   = 11'b000_0000_0010,
        S_BMUL  = 11'b000_0000_0100,
        S_BACC  = 11'b000_0000_1000,
        S_BWR   = 11'b000_0001_0000,
        S_TRD   = 11'b000_0010_0000,
        S_TCOEF = 11'b000_0100_0000,
        S_TMUL  = 11'b000_1000_0000,
        S_TACC  = 11'b001_0000_0000,
        S_TCHK  = 11'b010_0000_0000,
        S_TOUT  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic signed [VAL_W-1:0] proj_mem [16];
    logic signed [VAL_W-1:0] view_mem [16];
    logic signed [VAL_W-1:0] clip_mem [16];
    logic [15:0] proj_vld_reg, view_vld_reg, clip_vld_reg;

    logic signed [VAL_W-1:0] view_rd_reg, proj_rd_reg, w_rd_reg, s_rd_reg;
    logic signed [VAL_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [OPND_W-1:0] coef_reg, opnd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [1:0] row_reg, col_reg, k_reg;
    logic [PLANE_W-1:0] plane_reg;
    logic nrm_zero_reg, inside_reg, out_valid_reg, out_res_reg;

    logic accept;
    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0]  acc_shift;
    logic signed [VAL_W-1:0]  clip_sat;
    logic [IDX_W-1:0] view_idx, proj_idx, clip_idx, w_idx, s_idx;
    logic plane_fail;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.inside_res = out_res_reg;

    assign view_idx = {row_reg, k_reg};
    assign proj_idx = {k_reg, col_reg};
    assign clip_idx = {row_reg, col_reg};
    assign w_idx    = {k_reg, 2'd3};
    assign s_idx    = {k_reg, plane_col(plane_reg)};

    // The shared multiplier: matrix elements during a build, plane terms during a test.
    always_comb
    begin
        if (state_reg == S_BMUL)
        begin
            mul_a = {view_rd_reg[VAL_W-1], view_rd_reg};
            mul_b = {proj_rd_reg[VAL_W-1], proj_rd_reg};
        end
        else
        begin
            mul_a = coef_reg;
            mul_b = opnd_reg;
        end
    end

    // Floor to the fraction width, then saturate to 32 bits.
    always_comb
    begin
        acc_shift = acc_reg >>> FRAC_BITS;
        if (&acc_shift[ACC_W-1:VAL_W-1] || ~|acc_shift[ACC_W-1:VAL_W-1])
            clip_sat = acc_shift[VAL_W-1:0];
        else if (acc_shift[ACC_W-1])
            clip_sat = {1'b1, {(VAL_W-1){1'b0}}};
        else
            clip_sat = {1'b0, {(VAL_W-1){1'b1}}};
    end

    // With a zero normal the sum is just the offset, which rejects only when negative.
    assign plane_fail = nrm_zero_reg ? coef_reg[OPND_W-1]
                                     : (acc_reg[ACC_W-1] || (acc_reg == '0));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_ch.req_type == REQ_BUILD)
                    state_next = S_BRD;
                else if (accept && in_ch.req_type == REQ_TEST)
                    state_next = S_TRD;
            end
            S_BRD:   state_next = S_BMUL;
            S_BMUL:  state_next = S_BACC;
            S_BACC:  state_next = (k_reg == 2'd3) ? S_BWR : S_BRD;
            S_BWR:   state_next = (row_reg == 2'd3 && col_reg == 2'd3) ? S_IDLE : S_BRD;
            S_TRD:   state_next = S_TCOEF;
            S_TCOEF: state_next = S_TMUL;
            S_TMUL:  state_next = S_TACC;
            S_TACC:  state_next = (k_reg == 2'd3) ? S_TCHK : S_TRD;
            S_TCHK:
                state_next = (plane_reg == PLANE_W'(PLANE_COUNT - 1)) ? S_TOUT : S_TRD;
            S_TOUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            proj_vld_reg  <= '0;
            view_vld_reg  <= '0;
            clip_vld_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            plane_reg     <= '0;
            nrm_zero_reg  <= 1'b1;
            inside_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
            out_res_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_TOUT && (!out_valid_reg || out_ch.ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    row_reg      <= '0;
                    col_reg      <= '0;
                    k_reg        <= '0;
                    plane_reg    <= '0;
                    nrm_zero_reg <= 1'b1;
                    inside_reg   <= 1'b1;
                    if (accept && in_ch.req_type == REQ_LOAD_PROJ)
                        proj_vld_reg[in_ch.elem_index] <= 1'b1;
                    if (accept && in_ch.req_type == REQ_LOAD_VIEW)
                        view_vld_reg[in_ch.elem_index] <= 1'b1;
                end
                S_BACC: k_reg <= k_reg + 2'd1;
                S_BWR:
                begin
                    clip_vld_reg[clip_idx] <= 1'b1;
                    {row_reg, col_reg} <= {row_reg, col_reg} + 4'd1;
                end
                S_TMUL:
                begin
                    if (k_reg != 2'd3 && coef_reg != '0)
                        nrm_zero_reg <= 1'b0;
                end
                S_TACC: k_reg <= k_reg + 2'd1;
                S_TCHK:
                begin
                    if (plane_fail)
                        inside_reg <= 1'b0;
                    plane_reg    <= plane_reg + PLANE_W'(1);
                    nrm_zero_reg <= 1'b1;
                end
                S_TOUT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                        out_res_reg <= inside_reg;
                end
                default: ;
            endcase
        end
    end

    // Storage, read ports and datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept && in_ch.req_type == REQ_LOAD_PROJ)
            proj_mem[in_ch.elem_index] <= in_ch.elem_value;
        if (accept && in_ch.req_type == REQ_LOAD_VIEW)
            view_mem[in_ch.elem_index] <= in_ch.elem_value;
        if (accept && in_ch.req_type == REQ_TEST)
        begin
            px_reg <= in_ch.point_x;
            py_reg <= in_ch.point_y;
            pz_reg <= in_ch.point_z;
        end
        if (state_reg == S_BWR)
            clip_mem[clip_idx] <= clip_sat;

        view_rd_reg <= view_vld_reg[view_idx] ? view_mem[view_idx] : '0;
        proj_rd_reg <= proj_vld_reg[proj_idx] ? proj_mem[proj_idx] : '0;
        w_rd_reg    <= clip_vld_reg[w_idx] ? clip_mem[w_idx] : '0;
        s_rd_reg    <= clip_vld_reg[s_idx] ? clip_mem[s_idx] : '0;

        if (state_reg == S_TCOEF)
        begin
            if (plane_neg(plane_reg))
                coef_reg <= {w_rd_reg[VAL_W-1], w_rd_reg} - {s_rd_reg[VAL_W-1], s_rd_reg};
            else
                coef_reg <= {w_rd_reg[VAL_W-1], w_rd_reg} + {s_rd_reg[VAL_W-1], s_rd_reg};
            case (k_reg)
                2'd0:    opnd_reg <= {px_reg[VAL_W-1], px_reg};
                2'd1:    opnd_reg <= {py_reg[VAL_W-1], py_reg};
                2'd2:    opnd_reg <= {pz_reg[VAL_W-1], pz_reg};
                default: opnd_reg <= D_SCALE;
            endcase
        end

        if (state_reg == S_BMUL || state_reg == S_TMUL)
            prod_reg <= mul_a * mul_b;

        if (state_reg == S_IDLE || state_reg == S_BWR || state_reg == S_TCHK)
            acc_reg <= '0;
        else if (state_reg == S_BACC || state_reg == S_TACC)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

`ifndef NO_ASSERTIONS
    a_test_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.req_type == REQ_TEST) |=> !in_ch.ready)
        else $error("point test did not start its sequence");

    a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_ch.req_type == REQ_LOAD_PROJ || in_ch.req_type == REQ_LOAD_VIEW))
        |=> in_ch.ready)
        else $error("element load left the block busy");

    a_word_from_test: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_TOUT))
        else $error("result word raised outside the test sequence");

    a_check_after_last_term: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TCHK) |-> (k_reg == 2'd0 && $past(state_reg == S_TACC)))
        else $error("plane checked before all four terms were summed");
`endif

endmodule

>>> dv/frustum_plane_extract_and_point_test_chk.sv
`timescale 1ns / 100ps
// Checker for the frustum plane block: follows the request and result channels,
// predicts each inside flag and compares. Uses fpe_pkg, fpe_in_if and fpe_out_if.
module frustum_plane_extract_and_point_test_chk
    import fpe_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    fpe_in_if    in_ch,
    fpe_out_if   out_ch,
    output int   fail_count,
    output int   pending,
    output int   tests_seen,
    output int   builds_seen
);

    logic signed [31:0] proj_mat [16];
    logic signed [31:0] view_mat [16];
    logic signed [32:0] planes   [24];
    bit                 inside_expected [$];

    // Plane order: right, left, bottom, top, far, near.
    localparam int COL_OF [6] = '{0, 0, 1, 1, 2, 2};
    localparam bit NEG_OF [6] = '{1, 0, 0, 1, 1, 0};

    function automatic logic signed [31:0] combined_entry(input int r, input int c);
        logic signed [67:0] sum;
        logic signed [67:0] term;
        logic signed [67:0] shifted;
        sum = '0;
        for (int k = 0; k < 4; k++)
        begin
            term = 68'(view_mat[4*r+k]) * 68'(proj_mat[4*k+c]);
            sum  = sum + term;
        end
        shifted = sum >>> FRAC_BITS;
        if (shifted > 68'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (shifted < -68'sh80000000)
            return 32'sh80000000;
        return shifted[31:0];
    endfunction

    task automatic rebuild_planes();
        logic signed [31:0] clip_m [16];
        logic signed [32:0] w;
        logic signed [32:0] s;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                clip_m[4*r+c] = combined_entry(r, c);
        for (int p = 0; p < 6; p++)
            for (int j = 0; j < 4; j++)
            begin
                w = 33'(clip_m[4*j+3]);
                s = 33'(clip_m[4*j+COL_OF[p]]);
                planes[4*p+j] = NEG_OF[p] ? w - s : w + s;
            end
    endtask

    function automatic bit point_is_inside(input logic signed [31:0] x,
                                           input logic signed [31:0] y,
                                           input logic signed [31:0] z);
        logic signed [80:0] acc;
        logic signed [80:0] a, b, c, d;
        for (int p = 0; p < 6; p++)
        begin
            a = 81'(planes[4*p]);
            b = 81'(planes[4*p+1]);
            c = 81'(planes[4*p+2]);
            d = 81'(planes[4*p+3]);
            // A degenerate plane only rejects on a negative offset.
            if (a == 0 && b == 0 && c == 0)
            begin
                if (d < 0)
                    return 1'b0;
            end
            else
            begin
                acc = a * 81'(x) + b * 81'(y) + c * 81'(z) + (d <<< FRAC_BITS);
                if (acc <= 0)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                proj_mat[i] = '0;
                view_mat[i] = '0;
            end
            for (int i = 0; i < 24; i++)
                planes[i] = '0;
            inside_expected.delete();
            fail_count  = 0;
            pending     = 0;
            tests_seen  = 0;
            builds_seen = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (inside_expected.size() == 0)
                begin
                    $display("%0t: unexpected result word, inside_res=%0b", $time,
                             out_ch.inside_res);
                    fail_count++;
                end
                else
                begin
                    bit want;
                    want = inside_expected.pop_front();
                    if (out_ch.inside_res !== want)
                    begin
                        $display("%0t: inside_res mismatch, expected %0b actual %0b",
                                 $time, want, out_ch.inside_res);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                case (in_ch.req_type)
                    REQ_LOAD_PROJ: proj_mat[in_ch.elem_index] = in_ch.elem_value;
                    REQ_LOAD_VIEW: view_mat[in_ch.elem_index] = in_ch.elem_value;
                    REQ_BUILD:
                    begin
                        rebuild_planes();
                        builds_seen++;
                    end
                    default:
                    begin
                        inside_expected.push_back(point_is_inside(in_ch.point_x,
                                                  in_ch.point_y, in_ch.point_z));
                        tests_seen++;
                    end
                endcase
            end
            pending = inside_expected.size();
        end
    end

endmodule

>>> dv/frustum_plane_extract_and_point_test_tb.sv
`timescale 1ns / 100ps
// Testbench top for the frustum plane block: clock, reset, request stimulus and
// result back-pressure. Uses fpe_pkg, the channel interfaces and the checker module.
module frustum_plane_extract_and_point_test_tb;
    import fpe_pkg::*;

    localparam int ONE       = 65536;
    localparam int MAX_CYCLE = 1500000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   tests_seen;
    int   builds_seen;
    int   cycle_count;
    int   words_sent;
    bit   sink_stalls;

    fpe_in_if  in_ch ();
    fpe_out_if out_ch ();

    frustum_plane_extract_and_point_test uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    frustum_plane_extract_and_point_test_chk chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fail_count  (fail_count),
        .pending     (pending),
        .tests_seen  (tests_seen),
        .builds_seen (builds_seen)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: stalls come in bursts, with stretches of constant readiness.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (!sink_stalls)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 99) < 60);
    end

    initial
    begin
        sink_stalls = 1'b0;
        forever
        begin
            repeat ($urandom_range(50, 400)) @(negedge clk);
            sink_stalls = ($urandom_range(0, 3) != 0);
        end
    end

    // Drives one word at the current falling edge, holds it until it is taken,
    // then idles for a random gap. Valid stays high when no gap follows.
    task automatic send_word(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                             input logic [31:0] val, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        int g;
        in_ch.valid      <= 1'b1;
        in_ch.req_type   <= req;
        in_ch.elem_index <= idx;
        in_ch.elem_value <= val;
        in_ch.point_x    <= x;
        in_ch.point_y    <= y;
        in_ch.point_z    <= z;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
        g = gap_length();
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic load_elem(input logic [REQ_W-1:0] req, input int idx, input int val);
        send_word(req, idx[IDX_W-1:0], val, $urandom, $urandom, $urandom);
    endtask

    task automatic test_point(input int x, input int y, input int z);
        send_word(REQ_TEST, IDX_W'($urandom), $urandom, x, y, z);
    endtask

    task automatic build();
        send_word(REQ_BUILD, IDX_W'($urandom), $urandom, $urandom, $urandom, $urandom);
    endtask

    function automatic int near_value(input int scale);
        return $signed($urandom_range(0, 2 * scale)) - scale;
    endfunction

    // A plausible camera: each matrix is near identity with small random terms.
    task automatic camera_sequence();
        int n;
        for (int i = 0; i < 16; i++)
        begin
            load_elem(REQ_LOAD_PROJ, i, ((i % 5) == 0 ? ONE : 0) + near_value(ONE / 4));
            load_elem(REQ_LOAD_VIEW, i, ((i % 5) == 0 ? ONE : 0) + near_value(ONE / 4));
        end
        build();
        n = $urandom_range(6, 14);
        for (int i = 0; i < n; i++)
            test_point(near_value(2 * ONE), near_value(2 * ONE), near_value(2 * ONE));
    endtask

    task automatic noise_word();
        send_word(REQ_W'($urandom), IDX_W'($urandom), $urandom, $urandom, $urandom,
                  $urandom);
    endtask

    initial
    begin
        int roll;
        cycle_count      = 0;
        words_sent       = 0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.req_type   = REQ_LOAD_PROJ;
        in_ch.elem_index = '0;
        in_ch.elem_value = '0;
        in_ch.point_x    = '0;
        in_ch.point_y    = '0;
        in_ch.point_z    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Before any build every plane is zero, so any point counts as inside.
        test_point(32'h80000000, 32'h7FFFFFFF, 0);
        for (int i = 0; i < 16; i += 5)
        begin
            load_elem(REQ_LOAD_PROJ, i, ONE);
            load_elem(REQ_LOAD_VIEW, i, ONE);
        end
        build();
        test_point(0, 0, 0);
        test_point(2 * ONE, 0, 0);
        test_point(32'h80000000, 32'h80000000, 32'h80000000);
        test_point(ONE - 1, -(ONE - 1), ONE / 2);
        // Only the w-w term is left and it is negative: every plane is degenerate.
        load_elem(REQ_LOAD_PROJ, 0, 0);
        load_elem(REQ_LOAD_PROJ, 5, 0);
        load_elem(REQ_LOAD_PROJ, 10, 0);
        load_elem(REQ_LOAD_PROJ, 15, -ONE);
        build();
        test_point(0, 0, 0);
        // Saturating clip entries.
        load_elem(REQ_LOAD_PROJ, 0, 32'h7FFFFFFF);
        load_elem(REQ_LOAD_VIEW, 0, 32'h7FFFFFFF);
        load_elem(REQ_LOAD_VIEW, 15, 32'h80000000);
        load_elem(REQ_LOAD_PROJ, 15, 32'h7FFFFFFF);
        build();
        test_point(32'h7FFFFFFF, 0, 0);
        test_point(32'h80000000, 0, 0);

        while (words_sent < 1200)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 12)
                noise_word();
            else if (roll < 16)
            begin
                // Partial reload of a matrix with a fresh build.
                repeat ($urandom_range(1, 4))
                    load_elem(REQ_W'($urandom_range(0, 1)), $urandom_range(0, 15),
                              $urandom);
                build();
            end
            else if (roll < 20)
                test_point($urandom, $urandom, $urandom);
            else
                camera_sequence();
            if (words_sent > 600 && words_sent < 660)
                drain();
        end

        drain();
        repeat (300) @(posedge clk);
        $display("Sent %0d request words: %0d builds and %0d point tests checked.",
                 words_sent, builds_seen, tests_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
